@@ sv/minimum_spanning_tree_kruskal_top_assert.svh @@
// Assertion macros for the spanning tree block.
// Used by minimum_spanning_tree_kruskal_top; expects clk and rst_n in scope.
`ifndef MINIMUM_SPANNING_TREE_KRUSKAL_TOP_ASSERT_SVH
`define MINIMUM_SPANNING_TREE_KRUSKAL_TOP_ASSERT_SVH

// same-cycle implication
`define MSTK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication
`define MSTK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

@@ sv/mstk_pkg.sv @@
// Package for the spanning tree block: controller states, command and status words.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mstk_pkg;

  localparam int COST_W  = 16;
  localparam int TOTAL_W = 22;
  localparam logic [COST_W-1:0] COST_BIAS = 16'h8000;

  typedef enum logic [3:0] {
    S_LOAD,
    S_INIT,
    S_SCAN_START,
    S_SCAN,
    S_FIND,
    S_DECIDE,
    S_PUSH,
    S_REL_RD,
    S_REL_WR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic store;
    logic vx_rst;
    logic vx_init;
    logic scan_rst;
    logic scan_step;
    logic lab_rd;
    logic lab_save;
    logic rel_rd;
    logic rel_wr;
    logic pend_load;
    logic out_load;
    logic out_last;
    logic run_clr;
  } cmd_t;

  typedef struct packed {
    logic vx_last;
    logic scan_done;
    logic found;
    logic same_set;
    logic have_pend;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

@@ sv/minimum_spanning_tree_kruskal_top.sv @@
// Minimum spanning forest over a loaded edge list (Kruskal, label-merge union-find).
// Instantiates mstk_ctrl and mstk_datapath; uses mstk_pkg and the assertion header.
//
// Input channel (in_*): one edge word per accepted cycle while loading; in_stall is
// low in that phase, so edges load one per cycle. The word with in_edge_last set
// starts the run and in_stall stays high until the final result has been loaded.
// Run: label init over all MAX_VERTICES vertices, then one pass over the stored
// edges per distinct in-range edge word, plus a final pass that finds nothing. A pass
// is a restart, then one memory read a cycle; a pass that finds an edge adds the
// label read and the decision, and a selected edge adds a push and a relabel sweep,
// a read and a write per vertex.
// Output channel (out_*): results sit in an output register; a stalled result holds
// and the controller waits before loading the next one. The last result carries
// out_result_last; an empty tree gives one result with out_edge_valid low. Config
// (cfg_we/cfg_wdata) sets the vertex count; the user must write it while idle, which
// the block does not enforce. Synchronous reset returns to loading, store empty.
`timescale 1ns / 1ps
`default_nettype none
`include "minimum_spanning_tree_kruskal_top_assert.svh"
module minimum_spanning_tree_kruskal_top
  import mstk_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [$clog2(MAX_VERTICES+1)-1:0]   cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]     in_edge_from,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]     in_edge_to,
  input  wire logic signed [COST_W-1:0]            in_edge_cost,
  input  wire logic                                in_edge_last,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [$clog2(MAX_VERTICES)-1:0]          out_tree_from,
  output logic [$clog2(MAX_VERTICES)-1:0]          out_tree_to,
  output logic                                     out_edge_valid,
  output logic signed [TOTAL_W-1:0]                out_running_total,
  output logic                                     out_overflow,
  output logic                                     out_result_last
);

  cmd_t cmd;
  sts_t sts;

  mstk_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_edge_last (in_edge_last),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  mstk_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_edge_from      (in_edge_from),
    .in_edge_to        (in_edge_to),
    .in_edge_cost      (in_edge_cost),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tree_from     (out_tree_from),
    .out_tree_to       (out_tree_to),
    .out_edge_valid    (out_edge_valid),
    .out_running_total (out_running_total),
    .out_overflow      (out_overflow),
    .out_result_last   (out_result_last)
  );

  `MSTK_ASSERT_NOW(a_empty_is_last, out_valid && !out_edge_valid, out_result_last)
  `MSTK_ASSERT_NEXT(a_last_taken_idle, out_valid && !out_stall && out_result_last, !out_valid)
  `MSTK_ASSERT_NEXT(a_run_starts, in_valid && !in_stall && in_edge_last, in_stall)

endmodule
`default_nettype wire

@@ sv/mstk_datapath.sv @@
// Datapath: edge store, min-above-bound scan, vertex label memory, totals, output word.
// Depends on mstk_pkg; driven by mstk_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none
module mstk_datapath
  import mstk_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire cmd_t                                cmd,
  output sts_t                                     sts,
  input  wire logic                                cfg_we,
  input  wire logic [$clog2(MAX_VERTICES+1)-1:0]   cfg_wdata,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]     in_edge_from,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]     in_edge_to,
  input  wire logic signed [COST_W-1:0]            in_edge_cost,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [$clog2(MAX_VERTICES)-1:0]          out_tree_from,
  output logic [$clog2(MAX_VERTICES)-1:0]          out_tree_to,
  output logic                                     out_edge_valid,
  output logic signed [TOTAL_W-1:0]                out_running_total,
  output logic                                     out_overflow,
  output logic                                     out_result_last
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int NVW = $clog2(MAX_VERTICES+1);
  localparam int EAW = $clog2(MAX_EDGES);
  localparam int CW  = $clog2(MAX_EDGES+1);
  localparam int WW  = COST_W + 2*VW;

  logic [WW-1:0] edge_mem [MAX_EDGES];
  logic [VW-1:0] lab_mem  [MAX_VERTICES];

  logic [NVW-1:0] nv_r;
  logic [NVW-1:0] nv_eff;
  logic [CW-1:0]  cnt_r;
  logic           ovf_r;
  logic [CW-1:0]  scan_idx_r;
  logic           scan_pend_r;
  logic [WW-1:0]  edge_q_r;
  logic [WW-1:0]  best_r;
  logic           found_r;
  logic [WW-1:0]  prev_r;
  logic           have_prev_r;
  logic [VW-1:0]  vidx_r;
  logic [VW-1:0]  lab_a_r, lab_b_r, ru_r, rv_r;
  logic [VW-1:0]  pend_from_r, pend_to_r;
  logic           have_pend_r;
  logic [TOTAL_W-1:0] tot_r;
  logic [TOTAL_W-1:0] tot_nxt;
  logic           cand;
  logic           lab_we;
  logic [VW-1:0]  lab_wd, lab_ra;
  logic [VW-1:0]  qf, qt, best_from, best_to;
  logic [COST_W-1:0] best_cost;

  assign nv_eff    = (nv_r > NVW'(MAX_VERTICES)) ? NVW'(MAX_VERTICES) : nv_r;
  assign qf        = edge_q_r[2*VW-1:VW];
  assign qt        = edge_q_r[VW-1:0];
  assign best_from = best_r[2*VW-1:VW];
  assign best_to   = best_r[VW-1:0];
  assign best_cost = best_r[WW-1:2*VW] ^ COST_BIAS;
  assign tot_nxt   = tot_r + {{(TOTAL_W-COST_W){best_cost[COST_W-1]}}, best_cost};

  assign cand = scan_pend_r && (NVW'(qf) < nv_eff) && (NVW'(qt) < nv_eff)
             && (!have_prev_r || edge_q_r > prev_r)
             && (!found_r || edge_q_r < best_r);

  always_comb begin
    lab_we = cmd.vx_init | (cmd.rel_wr & (lab_a_r == ru_r));
    lab_wd = cmd.vx_init ? vidx_r : rv_r;
    lab_ra = cmd.rel_rd ? vidx_r : best_from;
  end

  always_ff @(posedge clk) begin
    if (cmd.store && cnt_r < CW'(MAX_EDGES)) begin
      edge_mem[cnt_r[EAW-1:0]] <= {in_edge_cost ^ COST_BIAS, in_edge_from, in_edge_to};
    end
    if (cmd.scan_step && scan_idx_r < cnt_r) begin
      edge_q_r <= edge_mem[scan_idx_r[EAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (lab_we) begin
      lab_mem[vidx_r] <= lab_wd;
    end
    if (cmd.lab_rd || cmd.rel_rd) begin
      lab_a_r <= lab_mem[lab_ra];
    end
    if (cmd.lab_rd) begin
      lab_b_r <= lab_mem[best_to];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cand) begin
      best_r <= edge_q_r;
    end
    if (cmd.lab_rd) begin
      prev_r <= best_r;
    end
    if (cmd.lab_save) begin
      ru_r <= lab_a_r;
      rv_r <= lab_b_r;
    end
    if (cmd.pend_load) begin
      pend_from_r <= best_from;
      pend_to_r   <= best_to;
    end
    if (cmd.out_load) begin
      out_tree_from     <= have_pend_r ? pend_from_r : '0;
      out_tree_to       <= have_pend_r ? pend_to_r : '0;
      out_edge_valid    <= have_pend_r;
      out_running_total <= have_pend_r ? tot_r : '0;
      out_overflow      <= ovf_r;
      out_result_last   <= cmd.out_last;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r        <= NVW'(MAX_VERTICES);
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      scan_idx_r  <= '0;
      scan_pend_r <= 1'b0;
      found_r     <= 1'b0;
      have_prev_r <= 1'b0;
      have_pend_r <= 1'b0;
      tot_r       <= '0;
      vidx_r      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        nv_r <= cfg_wdata;
      end
      if (cmd.store) begin
        if (cnt_r < CW'(MAX_EDGES)) begin
          cnt_r <= cnt_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.scan_rst) begin
        scan_idx_r  <= '0;
        scan_pend_r <= 1'b0;
        found_r     <= 1'b0;
      end else if (cmd.scan_step) begin
        if (scan_idx_r < cnt_r) begin
          scan_idx_r  <= scan_idx_r + 1'b1;
          scan_pend_r <= 1'b1;
        end else begin
          scan_pend_r <= 1'b0;
        end
        if (cand) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.lab_rd) begin
        have_prev_r <= 1'b1;
      end
      if (cmd.vx_rst) begin
        vidx_r <= '0;
      end else if (cmd.vx_init || cmd.rel_wr) begin
        vidx_r <= vidx_r + 1'b1;
      end
      if (cmd.pend_load) begin
        have_pend_r <= 1'b1;
        tot_r       <= tot_nxt;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.run_clr) begin
        cnt_r       <= '0;
        ovf_r       <= 1'b0;
        have_prev_r <= 1'b0;
        have_pend_r <= 1'b0;
        tot_r       <= '0;
      end
    end
  end

  always_comb begin
    sts.vx_last   = (vidx_r == VW'(MAX_VERTICES-1));
    sts.scan_done = (scan_idx_r == cnt_r) && !scan_pend_r;
    sts.found     = found_r;
    sts.same_set  = (lab_a_r == lab_b_r);
    sts.have_pend = have_pend_r;
    sts.out_busy  = out_valid;
  end

endmodule
`default_nettype wire

@@ sv/mstk_ctrl.sv @@
// Controller state machine: load, label init, scan, union test, relabel, emit.
// Depends on mstk_pkg; drives mstk_datapath.
`timescale 1ns / 1ps
`default_nettype none
module mstk_ctrl
  import mstk_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_edge_last,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic   in_acc;

  assign in_acc = in_valid && (state_r == S_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:       if (in_acc && in_edge_last) state_nxt = S_INIT;
      S_INIT:       if (sts.vx_last) state_nxt = S_SCAN_START;
      S_SCAN_START: state_nxt = S_SCAN;
      S_SCAN: begin
        if (sts.scan_done) state_nxt = sts.found ? S_FIND : S_FINISH;
      end
      S_FIND:       state_nxt = S_DECIDE;
      S_DECIDE:     state_nxt = sts.same_set ? S_SCAN_START : S_PUSH;
      S_PUSH:       if (!(sts.have_pend && sts.out_busy)) state_nxt = S_REL_RD;
      S_REL_RD:     state_nxt = S_REL_WR;
      S_REL_WR:     if (sts.vx_last) state_nxt = S_SCAN_START; else state_nxt = S_REL_RD;
      S_FINISH:     if (!sts.out_busy) state_nxt = S_LOAD;
      default:      state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != S_LOAD);
    unique case (state_r)
      S_LOAD: begin
        cmd.store  = in_acc;
        cmd.vx_rst = in_acc && in_edge_last;
      end
      S_INIT:       cmd.vx_init = 1'b1;
      S_SCAN_START: cmd.scan_rst = 1'b1;
      S_SCAN:       cmd.scan_step = 1'b1;
      S_FIND:       cmd.lab_rd = 1'b1;
      S_DECIDE: begin
        cmd.lab_save = 1'b1;
        cmd.vx_rst   = 1'b1;
      end
      S_PUSH: begin
        if (!(sts.have_pend && sts.out_busy)) begin
          cmd.out_load  = sts.have_pend;
          cmd.pend_load = 1'b1;
        end
      end
      S_REL_RD:     cmd.rel_rd = 1'b1;
      S_REL_WR:     cmd.rel_wr = 1'b1;
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          cmd.run_clr  = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ verif/minimum_spanning_tree_kruskal_top_test.sv @@
// Self-checking testbench for minimum_spanning_tree_kruskal_top: edge lists in, tree words out.
// Depends on mstk_pkg and the block itself; holds its own forest predictor in a scoreboard.
`timescale 1ns / 1ps

class mst_scoreboard;
  typedef struct packed {
    logic [5:0]  from_v;
    logic [5:0]  to_v;
    logic        valid;
    logic [21:0] total;
    logic        ovf;
    logic        last;
  } tree_word_t;

  tree_word_t  tree_q[$];
  bit [27:0]   edge_keys[$];
  bit          ovf_seen;
  int unsigned vertices_in_use = 64;
  int unsigned errors;
  int unsigned parent[64];
  int unsigned rank_of[64];

  function void set_vertices(bit [6:0] v);
    vertices_in_use = v;
  endfunction

  function int pending();
    return tree_q.size();
  endfunction

  function int unsigned root_of(int unsigned x);
    int unsigned r;
    int unsigned nx;
    r = x;
    while (parent[r] != r) r = parent[r];
    while (parent[x] != r) begin
      nx = parent[x];
      parent[x] = r;
      x = nx;
    end
    return r;
  endfunction

  function void note_edge(bit [5:0] f, bit [5:0] t, bit [15:0] c, bit l);
    bit [27:0]   sorted[$];
    bit [27:0]   w;
    int unsigned nv, ru, rv, s;
    int          j;
    bit [21:0]   sum;
    tree_word_t  tw;
    w = {c ^ 16'h8000, f, t};
    if (edge_keys.size() < 256) edge_keys.insert(edge_keys.size(), w);
    else ovf_seen = 1;
    if (!l) return;
    nv = (vertices_in_use > 64) ? 64 : vertices_in_use;
    for (int i = 0; i < 64; i++) begin
      parent[i] = i;
      rank_of[i] = 0;
    end
    foreach (edge_keys[i]) begin
      w = edge_keys[i];
      if (w[11:6] < nv && w[5:0] < nv) begin
        j = sorted.size();
        sorted.insert(sorted.size(), w);
        while (j > 0 && sorted[j-1] > w) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = w;
      end
    end
    sum = 0;
    s = 0;
    foreach (sorted[i]) begin
      w = sorted[i];
      ru = root_of(w[11:6]);
      rv = root_of(w[5:0]);
      if (ru != rv) begin
        if (rank_of[ru] > rank_of[rv]) begin
          j = ru; ru = rv; rv = j;
        end
        parent[ru] = rv;
        if (rank_of[ru] == rank_of[rv] && rank_of[rv] < 7) rank_of[rv]++;
        sum = sum + {{6{w[27] ^ 1'b1}}, w[27:12] ^ 16'h8000};
        tw = '{w[11:6], w[5:0], 1'b1, sum, ovf_seen, 1'b0};
        tree_q.insert(tree_q.size(), tw);
        s++;
      end
    end
    if (s == 0) begin
      tw = '{6'd0, 6'd0, 1'b0, 22'd0, ovf_seen, 1'b1};
      tree_q.insert(tree_q.size(), tw);
    end else begin
      tree_q[tree_q.size()-1].last = 1'b1;
    end
    edge_keys.delete();
    ovf_seen = 0;
  endfunction

  function void check(tree_word_t got);
    tree_word_t exp_w;
    if (tree_q.size() == 0) begin
      $error("unexpected tree word from=%0d to=%0d", got.from_v, got.to_v);
      errors++;
      return;
    end
    exp_w = tree_q.pop_front();
    if (got.from_v !== exp_w.from_v) begin
      $error("tree_from expected %0d got %0d", exp_w.from_v, got.from_v); errors++;
    end
    if (got.to_v !== exp_w.to_v) begin
      $error("tree_to expected %0d got %0d", exp_w.to_v, got.to_v); errors++;
    end
    if (got.valid !== exp_w.valid) begin
      $error("edge_valid expected %0d got %0d", exp_w.valid, got.valid); errors++;
    end
    if (got.total !== exp_w.total) begin
      $error("running_total expected %0d got %0d",
             $signed(exp_w.total), $signed(got.total)); errors++;
    end
    if (got.ovf !== exp_w.ovf) begin
      $error("overflow expected %0d got %0d", exp_w.ovf, got.ovf); errors++;
    end
    if (got.last !== exp_w.last) begin
      $error("result_last expected %0d got %0d", exp_w.last, got.last); errors++;
    end
  endfunction
endclass

module minimum_spanning_tree_kruskal_top_test;
  import mstk_pkg::*;

  logic              clk = 0;
  logic              rst_n = 0;
  logic              cfg_we = 0;
  logic [6:0]        cfg_wdata = 0;
  logic              in_valid = 0;
  logic              in_stall;
  logic [5:0]        in_edge_from = 0;
  logic [5:0]        in_edge_to = 0;
  logic [15:0]       in_edge_cost = 0;
  logic              in_edge_last = 0;
  logic              out_valid;
  logic              out_stall = 0;
  logic [5:0]        out_tree_from;
  logic [5:0]        out_tree_to;
  logic              out_edge_valid;
  logic [21:0]       out_running_total;
  logic              out_overflow;
  logic              out_result_last;

  mst_scoreboard sb = new();
  int unsigned   send_idle_pct = 32;
  int unsigned   recv_stall_pct = 32;
  int unsigned   cur_nv = 64;

  minimum_spanning_tree_kruskal_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_edge_from(in_edge_from),
    .in_edge_to(in_edge_to), .in_edge_cost(in_edge_cost), .in_edge_last(in_edge_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_tree_from(out_tree_from),
    .out_tree_to(out_tree_to), .out_edge_valid(out_edge_valid),
    .out_running_total(out_running_total), .out_overflow(out_overflow),
    .out_result_last(out_result_last)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check('{out_tree_from, out_tree_to, out_edge_valid, out_running_total,
                 out_overflow, out_result_last});
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_word(bit [5:0] f, bit [5:0] t, bit [15:0] c, bit l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid     <= 1;
    in_edge_from <= f;
    in_edge_to   <= t;
    in_edge_cost <= c;
    in_edge_last <= l;
    do @(posedge clk); while (in_stall);
    sb.note_edge(f, t, c, l);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_vertices(bit [6:0] v);
    cfg_we    <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 0;
    sb.set_vertices(v);
    cur_nv = v;
  endtask

  function automatic bit [5:0] pick_vertex();
    int unsigned span;
    span = (cur_nv == 0 || cur_nv > 64) ? 64 : cur_nv;
    if ($urandom_range(9) == 0) return 6'($urandom());
    return 6'($urandom_range(span - 1));
  endfunction

  task automatic random_graph(int n);
    bit [15:0] c;
    for (int i = 0; i < n; i++) begin
      c = ($urandom_range(2) == 0) ? 16'($urandom_range(7)) : 16'($urandom());
      send_word(pick_vertex(), pick_vertex(), c, i == n - 1);
    end
    drain();
  endtask

  initial begin
    bit [6:0] nv_list[$];
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // extremes, ties, self loop, duplicates
    send_word(63, 0, 16'h7FFF, 0);
    send_word(0, 63, 16'h8000, 0);
    send_word(5, 5, 16'h8000, 0);
    send_word(1, 2, 16'd3, 0);
    send_word(2, 1, 16'd3, 0);
    send_word(1, 2, 16'd3, 0);
    send_word(0, 1, 16'hFFFF, 0);
    send_word(62, 63, 16'h0000, 1);
    drain();
    send_word(7, 7, 16'd1, 1);
    drain();
    set_vertices(1);
    send_word(0, 0, 16'd4, 0);
    send_word(0, 1, 16'd4, 1);
    drain();
    set_vertices(0);
    send_word(0, 0, 16'd9, 1);
    drain();
    set_vertices(127);
    send_word(63, 62, 16'h8000, 0);
    send_word(62, 61, 16'h8000, 0);
    send_word(61, 63, 16'h7FFF, 1);
    drain();
    set_vertices(3);
    send_word(0, 2, 16'd1, 0);
    send_word(3, 1, 16'd1, 0);
    send_word(1, 2, 16'd2, 1);
    drain();

    nv_list = '{64, 2, 100, 5, 17, 33, 64, 9, 1, 64};
    foreach (nv_list[k]) begin
      set_vertices(nv_list[k]);
      if (k == 3) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else begin
        send_idle_pct = 32;
        recv_stall_pct = 32;
      end
      repeat (2) random_graph($urandom_range(1, 8));
    end

    // store overflow: long graph, full vertex range
    set_vertices(64);
    for (int i = 0; i < 262; i++)
      send_word(6'($urandom()), 6'($urandom()), 16'($urandom()), i == 261);
    drain();

    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+sv
sv/mstk_pkg.sv
sv/mstk_datapath.sv
sv/mstk_ctrl.sv
sv/minimum_spanning_tree_kruskal_top.sv
verif/minimum_spanning_tree_kruskal_top_test.sv
